// ===== rtl/dmsr_pkg.sv =====
package dmsr_pkg;

    localparam int SPEED_MAX   = 100;
    localparam int SERVO_MID   = 1500;
    localparam int SERVO_MIN   = 1000;
    localparam int SERVO_MAX   = 2000;
    localparam int PERIOD_MIN  = 50;
    // x/100 for x <= 25500 as (x * 5243) >> 19
    localparam int DUTY_RECIP  = 5243;
    localparam int DUTY_SHIFT  = 19;
    localparam int RES_DEPTH   = 4;

    typedef logic signed [7:0] t_spd;

    typedef enum logic [1:0] {
        MODE_TICK      = 2'd0,
        MODE_SET_LEFT  = 2'd1,
        MODE_SET_RIGHT = 2'd2,
        MODE_SET_BOTH  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        DRV_PWM4  = 2'd0,
        DRV_HB6   = 2'd1,
        DRV_SERVO = 2'd2,
        DRV_NONE  = 2'd3
    } t_drv;

    typedef enum logic [2:0] {
        CFG_DRIVER_TYPE  = 3'd0,
        CFG_STEP_UP      = 3'd1,
        CFG_STEP_DOWN    = 3'd2,
        CFG_RAMP_PERIOD  = 3'd3,
        CFG_INVERT_LEFT  = 3'd4,
        CFG_INVERT_RIGHT = 3'd5,
        CFG_SPARE6       = 3'd6,
        CFG_SPARE7       = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        t_drv        driver_type;
        logic [6:0]  step_up;
        logic [6:0]  step_down;
        logic [15:0] ramp_period;
        logic        invert_left;
        logic        invert_right;
    } t_cfg;

    typedef struct packed {
        logic        motor_index;
        logic        last_of_run;
        logic [7:0]  forward_duty;
        logic [7:0]  reverse_duty;
        logic [7:0]  enable_duty;
        logic        forward_pin;
        logic        reverse_pin;
        logic [10:0] servo_pulse_us;
    } t_result;

    // Per motor: emit flag and applied speed, index 0 left, 1 right
    typedef struct packed {
        logic [1:0]   vld;
        t_spd [1:0]   speed;
    } t_emit;

    typedef struct packed {
        logic [1:0]    vld;
        t_result [1:0] item;
    } t_push;

    function automatic t_spd sat_target(t_spd t);
        if (t > 8'sd100) begin
            return 8'sd100;
        end
        if (t < -8'sd100) begin
            return -8'sd100;
        end
        return t;
    endfunction

    function automatic logic [6:0] clamp_step(logic [6:0] s);
        return (s > 7'(SPEED_MAX)) ? 7'(SPEED_MAX) : s;
    endfunction

    // One slew step toward goal; accel adds magnitude, else removes it
    function automatic t_spd slew(t_spd cur, t_spd goal, logic [6:0] st, logic accel);
        logic signed [9:0] c;
        logic signed [9:0] g;
        logic signed [9:0] sum;
        logic signed [9:0] s;
        logic signed [9:0] moved;
        logic signed [9:0] res;
        c = 10'(cur);
        g = 10'(goal);
        s = signed'({3'b000, st});
        sum = c + g;
        if (st == 7'd0) begin
            return goal;
        end
        if (sum > 10'sd0) begin
            if (accel) begin
                moved = c + s;
                res = (moved > g) ? g : moved;
            end else begin
                moved = c - s;
                res = (moved < g) ? g : moved;
            end
        end else if (sum < 10'sd0) begin
            if (accel) begin
                moved = c - s;
                res = (moved < g) ? g : moved;
            end else begin
                moved = c + s;
                res = (moved > g) ? g : moved;
            end
        end else begin
            moved = '0;
            res = '0;
        end
        return t_spd'(res[7:0]);
    endfunction

    function automatic t_spd next_speed(t_spd cur, t_spd goal, logic [6:0] up,
                                        logic [6:0] down);
        if (goal == 8'sd0) begin
            return slew(cur, '0, down, 1'b0);
        end
        if (goal > 8'sd0) begin
            if (cur < 8'sd0) begin
                return slew(cur, '0, down, 1'b0);
            end
            return (cur <= goal) ? slew(cur, goal, up, 1'b1) : slew(cur, goal, down, 1'b0);
        end
        if (cur > 8'sd0) begin
            return slew(cur, '0, down, 1'b0);
        end
        return (cur >= goal) ? slew(cur, goal, up, 1'b1) : slew(cur, goal, down, 1'b0);
    endfunction

endpackage

// ===== rtl/dmsr_if.sv =====
interface dmsr_in_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            mode;
    logic signed [7:0]     target_speed;

    modport source (output valid, output mode, output target_speed, input ready);
    modport sink   (input valid, input mode, input target_speed, output ready);
endinterface

interface dmsr_out_if;
    logic        valid;
    logic        ready;
    logic        motor_index;
    logic        last_of_run;
    logic [7:0]  forward_duty;
    logic [7:0]  reverse_duty;
    logic [7:0]  enable_duty;
    logic        forward_pin;
    logic        reverse_pin;
    logic [10:0] servo_pulse_us;

    modport source (
        output valid, output motor_index, output last_of_run, output forward_duty,
        output reverse_duty, output enable_duty, output forward_pin, output reverse_pin,
        output servo_pulse_us, input ready
    );
    modport sink (
        input valid, input motor_index, input last_of_run, input forward_duty,
        input reverse_duty, input enable_duty, input forward_pin, input reverse_pin,
        input servo_pulse_us, output ready
    );
endinterface

// ===== rtl/dmsr_ramp.sv =====
module dmsr_ramp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  dmsr_pkg::t_mode i_mode,
    input  dmsr_pkg::t_spd  i_target,
    input  dmsr_pkg::t_cfg  i_cfg,
    output dmsr_pkg::t_emit o_emit
);

    logic [15:0]    r_tick_count;
    logic [15:0]    n_tick_count;
    dmsr_pkg::t_spd r_cur     [2];
    dmsr_pkg::t_spd n_cur     [2];
    dmsr_pkg::t_spd r_goal    [2];
    dmsr_pkg::t_spd n_goal    [2];
    dmsr_pkg::t_spd r_applied [2];
    dmsr_pkg::t_spd n_applied [2];

    dmsr_pkg::t_spd tgt;
    logic [15:0]    period;
    logic [15:0]    tick_inc;
    logic           is_tick;
    logic           do_step;
    logic [6:0]     up_step;
    logic [6:0]     down_step;
    logic [1:0]     inv;
    dmsr_pkg::t_spd stepped [2];
    dmsr_pkg::t_spd applied [2];

    assign tgt       = dmsr_pkg::sat_target(i_target);
    assign period    = (i_cfg.ramp_period < 16'(dmsr_pkg::PERIOD_MIN)) ?
                       16'(dmsr_pkg::PERIOD_MIN) : i_cfg.ramp_period;
    assign tick_inc  = r_tick_count + 16'd1;
    assign is_tick   = i_vld && (i_mode == dmsr_pkg::MODE_TICK);
    assign do_step   = is_tick && (tick_inc >= period);
    assign up_step   = dmsr_pkg::clamp_step(i_cfg.step_up);
    assign down_step = dmsr_pkg::clamp_step(i_cfg.step_down);
    assign inv       = {i_cfg.invert_right, i_cfg.invert_left};

    always_comb begin
        n_tick_count = r_tick_count;
        if (is_tick) begin
            n_tick_count = do_step ? 16'd0 : tick_inc;
        end
        for (int m = 0; m < 2; m++) begin
            n_cur[m]     = r_cur[m];
            n_goal[m]    = r_goal[m];
            n_applied[m] = r_applied[m];
            stepped[m]   = dmsr_pkg::next_speed(r_cur[m], r_goal[m], up_step, down_step);
            applied[m]   = inv[m] ? dmsr_pkg::t_spd'(-stepped[m]) : stepped[m];
            o_emit.vld[m]   = 1'b0;
            o_emit.speed[m] = applied[m];
            if (do_step && (r_cur[m] != r_goal[m])) begin
                n_cur[m] = stepped[m];
                if (applied[m] != r_applied[m]) begin
                    n_applied[m]  = applied[m];
                    o_emit.vld[m] = 1'b1;
                end
            end
        end
        // goal writes
        if (i_vld) begin
            case (i_mode)
                dmsr_pkg::MODE_SET_LEFT: begin
                    n_goal[0] = tgt;
                end
                dmsr_pkg::MODE_SET_RIGHT: begin
                    n_goal[1] = tgt;
                end
                dmsr_pkg::MODE_SET_BOTH: begin
                    n_goal[0] = tgt;
                    n_goal[1] = tgt;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= '0;
            for (int m = 0; m < 2; m++) begin
                r_cur[m]     <= '0;
                r_goal[m]    <= '0;
                r_applied[m] <= '0;
            end
        end else begin
            r_tick_count <= n_tick_count;
            for (int m = 0; m < 2; m++) begin
                r_cur[m]     <= n_cur[m];
                r_goal[m]    <= n_goal[m];
                r_applied[m] <= n_applied[m];
            end
        end
    end

endmodule

// ===== rtl/dmsr_encode.sv =====
module dmsr_encode (
    input  dmsr_pkg::t_drv    i_drv,
    input  dmsr_pkg::t_spd    i_speed,
    input  logic              i_motor_index,
    input  logic              i_last,
    output dmsr_pkg::t_result o_result
);

    logic [7:0]         neg;
    logic [6:0]         mag;
    logic [14:0]        scaled;
    logic [27:0]        prod;
    logic [7:0]         duty;
    logic signed [11:0] s12;
    logic signed [11:0] servo;

    assign neg    = 8'(-i_speed);
    assign mag    = (i_speed < 8'sd0) ? neg[6:0] : i_speed[6:0];
    // magnitude * 255 as a shift and subtract
    assign scaled = {mag, 8'b0} - 15'(mag);
    assign prod   = 28'(scaled) * 28'(dmsr_pkg::DUTY_RECIP);
    assign duty   = prod[dmsr_pkg::DUTY_SHIFT +: 8];
    assign s12    = 12'(i_speed);
    assign servo  = (s12 <<< 2) + s12 + 12'(dmsr_pkg::SERVO_MID);

    always_comb begin
        o_result             = '0;
        o_result.motor_index = i_motor_index;
        o_result.last_of_run = i_last;
        unique case (i_drv)
            dmsr_pkg::DRV_PWM4: begin
                o_result.forward_duty = (i_speed > 8'sd0) ? duty : 8'd0;
                o_result.reverse_duty = (i_speed < 8'sd0) ? duty : 8'd0;
            end
            dmsr_pkg::DRV_HB6: begin
                o_result.enable_duty = duty;
                o_result.forward_pin = i_speed > 8'sd0;
                o_result.reverse_pin = i_speed < 8'sd0;
            end
            dmsr_pkg::DRV_SERVO: begin
                o_result.servo_pulse_us = servo[10:0];
            end
            dmsr_pkg::DRV_NONE: begin
            end
        endcase
    end

endmodule

// ===== rtl/dmsr_fifo.sv =====
module dmsr_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dmsr_pkg::t_push   i_push,
    input  logic              i_pop,
    output logic              o_valid,
    output dmsr_pkg::t_result o_item,
    output logic [2:0]        o_count
);

    localparam int AW = $clog2(dmsr_pkg::RES_DEPTH);

    dmsr_pkg::t_result r_mem [dmsr_pkg::RES_DEPTH];
    logic [AW-1:0]     r_wp;
    logic [AW-1:0]     r_rp;
    logic [2:0]        r_count;
    logic [AW-1:0]     wp1;
    logic [1:0]        n_push;
    logic              pop;

    assign pop     = i_pop && (r_count != 3'd0);
    assign o_valid = r_count != 3'd0;
    assign o_item  = r_mem[r_rp];
    assign o_count = r_count;
    assign n_push  = 2'(i_push.vld[0]) + 2'(i_push.vld[1]);
    assign wp1     = r_wp + AW'(i_push.vld[0]);

    always_ff @(posedge i_clk) begin
        if (i_push.vld[0]) begin
            r_mem[r_wp] <= i_push.item[0];
        end
        if (i_push.vld[1]) begin
            r_mem[wp1] <= i_push.item[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + AW'(n_push);
            r_rp    <= r_rp + AW'(pop);
            r_count <= r_count + 3'(n_push) - 3'(pop);
        end
    end

endmodule

// ===== rtl/dual_motor_speed_ramp_driver_unit.sv =====
// Dual motor speed ramp driver. Items on i_in either set a signed speed goal (left,
// right or both, saturated to +/-100 percent) or carry a millisecond tick. Every
// ramp period of ticks each motor moves one step toward its goal and, when its
// applied speed (negated if that motor's invert bit is set) changes, one result item
// leaves on o_out with the drive values of the selected driver type: left motor
// first, last_of_run set on the final item of the tick. An item is registered on
// acceptance and processed in the next cycle, so goal writes and quiet ticks flow at
// one item per cycle while i_in stays ready; a tick that moves both motors yields two
// result items, while o_out delivers one item per cycle at most, so a run of such
// ticks is held back by the output. Results wait in a four-entry queue. i_in stays
// ready while the queue can still take two results for the item already registered
// and two for the next one: with a tick in the input register that means an empty
// queue, otherwise at most two results waiting. Configuration is written through
// i_cfg_we / i_cfg_idx / i_cfg_data and must only change while idle.
module dual_motor_speed_ramp_driver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dmsr_in_if.sink     i_in,
    dmsr_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    dmsr_pkg::t_cfg    r_cfg;
    logic              r_in_vld;
    dmsr_pkg::t_mode   r_in_mode;
    dmsr_pkg::t_spd    r_in_target;

    logic              in_acc;
    logic [2:0]        q_count;
    logic [2:0]        reserve;
    dmsr_pkg::t_emit   emit;
    dmsr_pkg::t_result res_left;
    dmsr_pkg::t_result res_right;
    dmsr_pkg::t_push   push;
    dmsr_pkg::t_result q_item;
    logic              q_valid;

    // Reserve two queue slots for a tick still in the input register
    assign reserve    = (r_in_vld && (r_in_mode == dmsr_pkg::MODE_TICK)) ? 3'd2 : 3'd0;
    assign i_in.ready = (q_count + reserve) <= 3'd2;
    assign in_acc     = i_in.valid && i_in.ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.driver_type  <= dmsr_pkg::DRV_PWM4;
            r_cfg.step_up      <= '0;
            r_cfg.step_down    <= '0;
            r_cfg.ramp_period  <= 16'(dmsr_pkg::PERIOD_MIN);
            r_cfg.invert_left  <= 1'b0;
            r_cfg.invert_right <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (dmsr_pkg::t_cfg_idx'(i_cfg_idx))
                dmsr_pkg::CFG_DRIVER_TYPE:  r_cfg.driver_type  <= dmsr_pkg::t_drv'(i_cfg_data[1:0]);
                dmsr_pkg::CFG_STEP_UP:      r_cfg.step_up      <= i_cfg_data[6:0];
                dmsr_pkg::CFG_STEP_DOWN:    r_cfg.step_down    <= i_cfg_data[6:0];
                dmsr_pkg::CFG_RAMP_PERIOD:  r_cfg.ramp_period  <= i_cfg_data;
                dmsr_pkg::CFG_INVERT_LEFT:  r_cfg.invert_left  <= i_cfg_data[0];
                dmsr_pkg::CFG_INVERT_RIGHT: r_cfg.invert_right <= i_cfg_data[0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_mode   <= dmsr_pkg::t_mode'(i_in.mode);
            r_in_target <= i_in.target_speed;
        end
    end

    // Ramp state and step decision
    dmsr_ramp u_ramp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_in_vld),
        .i_mode   (r_in_mode),
        .i_target (r_in_target),
        .i_cfg    (r_cfg),
        .o_emit   (emit)
    );

    // Drive values, one encoder per motor
    dmsr_encode u_enc_left (
        .i_drv         (r_cfg.driver_type),
        .i_speed       (emit.speed[0]),
        .i_motor_index (1'b0),
        .i_last        (!emit.vld[1]),
        .o_result      (res_left)
    );

    dmsr_encode u_enc_right (
        .i_drv         (r_cfg.driver_type),
        .i_speed       (emit.speed[1]),
        .i_motor_index (1'b1),
        .i_last        (1'b1),
        .o_result      (res_right)
    );

    assign push.vld     = emit.vld;
    assign push.item[0] = res_left;
    assign push.item[1] = res_right;

    // Result queue; left is written ahead of right
    dmsr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_out.ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .o_count (q_count)
    );

    assign o_out.valid          = q_valid;
    assign o_out.motor_index    = q_item.motor_index;
    assign o_out.last_of_run    = q_item.last_of_run;
    assign o_out.forward_duty   = q_item.forward_duty;
    assign o_out.reverse_duty   = q_item.reverse_duty;
    assign o_out.enable_duty    = q_item.enable_duty;
    assign o_out.forward_pin    = q_item.forward_pin;
    assign o_out.reverse_pin    = q_item.reverse_pin;
    assign o_out.servo_pulse_us = q_item.servo_pulse_us;

endmodule

// ===== rtl/dmsr_checker.sv =====
module dmsr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_motor_index,
    input logic        i_last_of_run,
    input logic [7:0]  i_forward_duty,
    input logic [7:0]  i_reverse_duty,
    input logic        i_forward_pin,
    input logic        i_reverse_pin,
    input logic [10:0] i_servo_pulse_us
);

    // hold a pending result until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    a_one_dir_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_forward_duty == 8'd0) || (i_reverse_duty == 8'd0))
        else $error("forward and reverse duty both driven");

    a_one_dir_pin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_forward_pin && i_reverse_pin))
        else $error("forward and reverse pins both high");

    a_servo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_servo_pulse_us != 11'd0) |->
            (i_servo_pulse_us >= 11'd1000) && (i_servo_pulse_us <= 11'd2000))
        else $error("servo pulse out of range");

    // a left item not marked last must be followed by the right item of the same tick
    a_left_then_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last_of_run |=> i_motor_index || !i_out_valid)
        else $error("unfinished run followed by a left item");

endmodule

bind dual_motor_speed_ramp_driver_unit dmsr_checker u_dmsr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_motor_index    (o_out.motor_index),
    .i_last_of_run    (o_out.last_of_run),
    .i_forward_duty   (o_out.forward_duty),
    .i_reverse_duty   (o_out.reverse_duty),
    .i_forward_pin    (o_out.forward_pin),
    .i_reverse_pin    (o_out.reverse_pin),
    .i_servo_pulse_us (o_out.servo_pulse_us)
);
